// File: rtl/spi_nor_flash_command_sequencer_top_assert.svh
// Assertion macros for the SPI NOR flash command sequencer.
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_TOP_ASSERT_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define SNF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SNF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SNF_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SNF_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/snf_pkg.sv
// ----------------------------------------------------------------------------
// snf_pkg
// Types and constants of the SPI NOR flash command sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package snf_pkg;
  typedef enum logic [3:0] {
    PH_IDLE, PH_COLLECT, PH_WEN, PH_CMD, PH_A2, PH_A1, PH_A0, PH_DATA,
    PH_POLLC, PH_POLLD
  } phase_t;

  localparam logic [3:0] T_READ = 4'd0, T_WRITE = 4'd1, T_SECTOR = 4'd2,
    T_BLOCK = 4'd3, T_CHIP = 4'd4, T_ID = 4'd5, T_STATUS = 4'd6, T_CRC = 4'd7,
    T_DATA = 4'd8, T_RX = 4'd9;

  localparam logic [2:0] OP_READ = 3'd0, OP_WRITE = 3'd1, OP_SECTOR = 3'd2,
    OP_BLOCK = 3'd3, OP_CHIP = 3'd4, OP_ID = 3'd5, OP_STATUS = 3'd6,
    OP_CRC = 3'd7;

  localparam logic [1:0] ST_OK = 2'd0, ST_RANGE = 2'd1, ST_ID = 2'd2, ST_BAD = 2'd3;

  localparam logic [7:0] CMD_WREN = 8'h06, CMD_RDSR = 8'h05, CMD_READ = 8'h03,
    CMD_PP = 8'h02, CMD_SE = 8'h20, CMD_BE = 8'hD8, CMD_CE = 8'hC7,
    CMD_RDID = 8'h9F, DUMMY = 8'hFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [0:0] CFG_ID = 1'b0, CFG_MASK = 1'b1;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       host_valid;
    logic [7:0] host_byte;
    logic [31:0] crc_value;
    logic       done_res;
    logic [1:0] status;
  } result_t;

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
    return r;
  endfunction
endpackage

// File: rtl/spi_nor_flash_command_sequencer_top.sv
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer_top
// Host request to SPI NOR byte sequencer with page buffer and CRC32.
// ----------------------------------------------------------------------------
// Usage: the input channel carries host requests, write data bytes and the
// byte received in each SPI exchange; one item is accepted per cycle at most.
// Every tx result must be answered by one rx item. The output channel carries
// at most one result per accepted item, registered through a two-entry
// buffer, so items are taken back to back while the output is free, except
// that after a data byte that fills a page the input stalls while the first
// page byte is fetched from the page memory before the next item; every page
// byte sent is fetched ahead from that memory's single registered read port.
// When the receiver stalls, the buffer fills and input stall rises after two
// held results. Reset returns the sequencer to idle with the configuration
// registers at their defaults; the page memory is not cleared and needs none.
// The configuration write channel is always ready and takes one register
// transaction per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "spi_nor_flash_command_sequencer_top_assert.svh"
module spi_nor_flash_command_sequencer_top #(
  parameter int PAGE_BYTES = 256,
  parameter int TOTAL_BYTES = 8388608,
  parameter int READ_FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  req_type,
  input  logic [23:0] address,
  input  logic [23:0] length,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        tx_valid,
  output logic [7:0]  tx_byte,
  output logic        frame_end,
  output logic        host_valid,
  output logic [7:0]  host_byte,
  output logic [31:0] crc_value,
  output logic        done_res,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  localparam int PW = $clog2(PAGE_BYTES);
  localparam int CW = $clog2(PAGE_BYTES + 1) > $clog2(READ_FRAME_BYTES + 1) ?
                      $clog2(PAGE_BYTES + 1) : $clog2(READ_FRAME_BYTES + 1);
  localparam int FW = $clog2(READ_FRAME_BYTES + 1) > 24 ? $clog2(READ_FRAME_BYTES + 1) : 24;
  localparam logic [24:0] TOTAL = 25'(TOTAL_BYTES);
  localparam logic [23:0] RFB = 24'(READ_FRAME_BYTES);

  logic [23:0] expected_id;
  logic [7:0]  busy_mask;
  snf_pkg::phase_t phase, phase_next;
  logic [2:0]  current_op, current_op_next;
  logic [23:0] cur_address, cur_address_next, remaining, remaining_next;
  logic [CW-1:0] chunk_bytes, chunk_bytes_next, byte_index, byte_index_next;
  logic [FW-1:0] frame_left, frame_left_next;
  logic [31:0] crc_reg, crc_reg_next;
  logic [23:0] id_shift, id_shift_next;
  logic fetch, fetch_next;
  snf_pkg::result_t res;
  logic res_valid, space, accept;
  logic [7:0] rd_data;
  logic [PW-1:0] raddr;
  logic we;
  snf_pkg::result_t out_r;

  assign cfg_ready = 1'b1;
  assign in_stall = !space || fetch;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= 24'hEF4017;
      busy_mask <= 8'h01;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        snf_pkg::CFG_ID:   expected_id <= cfg_data;
        snf_pkg::CFG_MASK: busy_mask <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign we = accept && phase == snf_pkg::PH_COLLECT && req_type == snf_pkg::T_DATA;
  // Read port looks ahead: the byte at byte_index_next is ready when sent.
  assign raddr = byte_index_next[PW-1:0];
  snf_page_ram #(.AW(PW)) u_ram (
    .clk(clk), .we(we), .waddr(byte_index[PW-1:0]), .wdata(data_byte),
    .raddr(raddr), .rdata(rd_data)
  );

  always_comb begin
    logic [23:0] room, c;
    logic [7:0] cmd;
    logic [FW-1:0] fl;
    logic do_send, fe, last_frame;
    logic [7:0] b;
    phase_next = phase; current_op_next = current_op; cur_address_next = cur_address;
    remaining_next = remaining; chunk_bytes_next = chunk_bytes;
    byte_index_next = byte_index; frame_left_next = frame_left;
    crc_reg_next = crc_reg; id_shift_next = id_shift; fetch_next = 1'b0;
    res = '0; res_valid = 1'b0;
    room = '0; c = '0; cmd = '0; fl = '0; do_send = 1'b0; fe = 1'b0; b = '0;
    last_frame = 1'b0;
    if (accept) begin
      res_valid = 1'b1;
      unique case (phase)
        snf_pkg::PH_IDLE: begin
          if (req_type <= snf_pkg::T_CRC) begin
            current_op_next = req_type[2:0];
            cur_address_next = address;
            unique case (req_type)
              snf_pkg::T_READ: begin
                frame_left_next = FW'(length); remaining_next = '0;
                res.tx_valid = 1'b1; res.tx_byte = snf_pkg::CMD_READ;
                phase_next = snf_pkg::PH_CMD;
              end
              snf_pkg::T_WRITE: begin
                if ({1'b0, address} + {1'b0, length} > TOTAL) begin
                  res.done_res = 1'b1; res.status = snf_pkg::ST_RANGE;
                end else if (length == 24'd0) begin
                  res.done_res = 1'b1;
                end else begin
                  res_valid = 1'b0;
                  room = 24'(PAGE_BYTES) - 24'(address[PW-1:0]);
                  c = length < room ? length : room;
                  chunk_bytes_next = CW'(c); remaining_next = length - c;
                  byte_index_next = '0; phase_next = snf_pkg::PH_COLLECT;
                end
              end
              snf_pkg::T_ID: begin
                frame_left_next = FW'(3); id_shift_next = '0;
                res.tx_valid = 1'b1; res.tx_byte = snf_pkg::CMD_RDID;
                phase_next = snf_pkg::PH_CMD;
              end
              snf_pkg::T_STATUS: begin
                frame_left_next = FW'(1);
                res.tx_valid = 1'b1; res.tx_byte = snf_pkg::CMD_RDSR;
                phase_next = snf_pkg::PH_CMD;
              end
              snf_pkg::T_CRC: begin
                crc_reg_next = '1;
                if (length == 24'd0) res.done_res = 1'b1;
                else begin
                  c = length < RFB ? length : RFB;
                  chunk_bytes_next = CW'(c); remaining_next = length - c;
                  frame_left_next = FW'(c);
                  res.tx_valid = 1'b1; res.tx_byte = snf_pkg::CMD_READ;
                  phase_next = snf_pkg::PH_CMD;
                end
              end
              default: begin
                frame_left_next = '0;
                res.tx_valid = 1'b1; res.tx_byte = snf_pkg::CMD_WREN;
                res.frame_end = 1'b1; phase_next = snf_pkg::PH_WEN;
              end
            endcase
          end else begin
            res = '0; res.status = snf_pkg::ST_BAD;
          end
        end
        snf_pkg::PH_COLLECT: begin
          if (req_type == snf_pkg::T_DATA) begin
            byte_index_next = byte_index + CW'(1);
            if (byte_index_next >= chunk_bytes) begin
              res.tx_valid = 1'b1; res.tx_byte = snf_pkg::CMD_WREN;
              res.frame_end = 1'b1; phase_next = snf_pkg::PH_WEN;
              byte_index_next = '0; fetch_next = 1'b1;
            end else res_valid = 1'b0;
          end else begin
            res = '0; res.status = snf_pkg::ST_BAD;
          end
        end
        default: begin
          if (req_type != snf_pkg::T_RX) begin
            res = '0; res.status = snf_pkg::ST_BAD;
          end else begin
            fl = frame_left;
            // Per phase: send the next command, address, data or poll byte, or end the frame.
            unique case (phase)
              snf_pkg::PH_WEN: begin
                byte_index_next = '0;
                frame_left_next = current_op == snf_pkg::OP_WRITE ? FW'(chunk_bytes) : '0;
                unique case (current_op)
                  snf_pkg::OP_WRITE:  cmd = snf_pkg::CMD_PP;
                  snf_pkg::OP_SECTOR: cmd = snf_pkg::CMD_SE;
                  snf_pkg::OP_BLOCK:  cmd = snf_pkg::CMD_BE;
                  default:            cmd = snf_pkg::CMD_CE;
                endcase
                res.tx_valid = 1'b1; res.tx_byte = cmd;
                res.frame_end = current_op == snf_pkg::OP_CHIP;
                phase_next = snf_pkg::PH_CMD;
              end
              snf_pkg::PH_CMD: begin
                if (current_op == snf_pkg::OP_CHIP) last_frame = 1'b1;
                else if (current_op == snf_pkg::OP_ID || current_op == snf_pkg::OP_STATUS)
                  do_send = 1'b1;
                else begin
                  res.tx_valid = 1'b1; res.tx_byte = cur_address[23:16];
                  phase_next = snf_pkg::PH_A2;
                end
              end
              snf_pkg::PH_A2: begin
                res.tx_valid = 1'b1; res.tx_byte = cur_address[15:8];
                phase_next = snf_pkg::PH_A1;
              end
              snf_pkg::PH_A1: begin
                res.tx_valid = 1'b1; res.tx_byte = cur_address[7:0];
                res.frame_end = frame_left == '0; phase_next = snf_pkg::PH_A0;
              end
              snf_pkg::PH_A0: begin
                if (frame_left != '0) do_send = 1'b1; else last_frame = 1'b1;
              end
              snf_pkg::PH_DATA: begin
                if (current_op == snf_pkg::OP_READ || current_op == snf_pkg::OP_ID ||
                    current_op == snf_pkg::OP_STATUS) begin
                  res.host_valid = 1'b1; res.host_byte = data_byte;
                end
                if (current_op == snf_pkg::OP_ID) id_shift_next = {id_shift[15:0], data_byte};
                if (current_op == snf_pkg::OP_CRC)
                  crc_reg_next = snf_pkg::crc_step(crc_reg, data_byte);
                if (frame_left != '0) do_send = 1'b1; else last_frame = 1'b1;
              end
              snf_pkg::PH_POLLC: begin
                res.tx_valid = 1'b1; res.tx_byte = snf_pkg::DUMMY;
                res.frame_end = 1'b1; phase_next = snf_pkg::PH_POLLD;
              end
              default: begin
                if ((data_byte & busy_mask) != 8'd0) begin
                  res.tx_valid = 1'b1; res.tx_byte = snf_pkg::CMD_RDSR;
                  phase_next = snf_pkg::PH_POLLC;
                end else if (current_op == snf_pkg::OP_WRITE) begin
                  cur_address_next = cur_address + 24'(chunk_bytes);
                  if (remaining == 24'd0) begin
                    res.done_res = 1'b1; phase_next = snf_pkg::PH_IDLE;
                  end else begin
                    res_valid = 1'b0;
                    room = 24'(PAGE_BYTES) - 24'(cur_address_next[PW-1:0]);
                    c = remaining < room ? remaining : room;
                    chunk_bytes_next = CW'(c); remaining_next = remaining - c;
                    byte_index_next = '0; phase_next = snf_pkg::PH_COLLECT;
                  end
                end else begin
                  res.done_res = 1'b1; phase_next = snf_pkg::PH_IDLE;
                end
              end
            endcase
            if (do_send) begin
              b = snf_pkg::DUMMY;
              if (current_op == snf_pkg::OP_WRITE) begin
                b = rd_data; byte_index_next = byte_index + CW'(1);
              end
              fl = frame_left - FW'(1);
              frame_left_next = fl;
              res.tx_valid = 1'b1; res.tx_byte = b; res.frame_end = fl == '0;
              phase_next = snf_pkg::PH_DATA;
            end
            if (last_frame) begin
              unique case (current_op) inside
                snf_pkg::OP_READ, snf_pkg::OP_STATUS: begin
                  res.done_res = 1'b1; phase_next = snf_pkg::PH_IDLE;
                end
                snf_pkg::OP_ID: begin
                  res.done_res = 1'b1; phase_next = snf_pkg::PH_IDLE;
                  res.status = id_shift_next == expected_id ? snf_pkg::ST_OK : snf_pkg::ST_ID;
                end
                snf_pkg::OP_CRC: begin
                  if (remaining != 24'd0) begin
                    cur_address_next = cur_address + 24'(chunk_bytes);
                    c = remaining < RFB ? remaining : RFB;
                    chunk_bytes_next = CW'(c); remaining_next = remaining - c;
                    frame_left_next = FW'(c);
                    res.tx_valid = 1'b1; res.tx_byte = snf_pkg::CMD_READ;
                    phase_next = snf_pkg::PH_CMD;
                  end else begin
                    res.crc_value = ~crc_reg_next; res.done_res = 1'b1;
                    phase_next = snf_pkg::PH_IDLE;
                  end
                end
                default: begin
                  res.tx_valid = 1'b1; res.tx_byte = snf_pkg::CMD_RDSR;
                  phase_next = snf_pkg::PH_POLLC;
                end
              endcase
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= snf_pkg::PH_IDLE;
      current_op <= '0; cur_address <= '0; remaining <= '0;
      chunk_bytes <= '0; byte_index <= '0; frame_left <= '0;
      crc_reg <= '1; id_shift <= '0; fetch <= 1'b0;
    end else begin
      phase <= phase_next; current_op <= current_op_next;
      cur_address <= cur_address_next; remaining <= remaining_next;
      chunk_bytes <= chunk_bytes_next; byte_index <= byte_index_next;
      frame_left <= frame_left_next; crc_reg <= crc_reg_next;
      id_shift <= id_shift_next; fetch <= fetch_next;
    end
  end

  snf_out_skid u_skid (
    .clk(clk), .rst(rst), .in_valid(res_valid), .in_data(res), .space(space),
    .out_valid(out_valid), .out_data(out_r), .out_stall(out_stall)
  );
  assign tx_valid = out_r.tx_valid;
  assign tx_byte = out_r.tx_byte;
  assign frame_end = out_r.frame_end;
  assign host_valid = out_r.host_valid;
  assign host_byte = out_r.host_byte;
  assign crc_value = out_r.crc_value;
  assign done_res = out_r.done_res;
  assign status = out_r.status;

  `SNF_ASSERT_NXT(a_fetch_stall, clk, rst, fetch_next && accept, in_stall, "fetch cycle not stalled")
  `SNF_ASSERT_IMP(a_no_write_idle, clk, rst, phase == snf_pkg::PH_IDLE, !we, "page write while idle")
  `SNF_ASSERT_IMP(a_chunk_le_page, clk, rst, phase == snf_pkg::PH_COLLECT, chunk_bytes <= CW'(PAGE_BYTES), "chunk too large")
endmodule

// File: rtl/snf_page_ram.sv
// ----------------------------------------------------------------------------
// snf_page_ram
// Page buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module snf_page_ram #(
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [(1<<AW)];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/snf_out_skid.sv
// ----------------------------------------------------------------------------
// snf_out_skid
// Two-entry result buffer that separates the core from the output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module snf_out_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  snf_pkg::result_t   in_data,
  output logic               space,
  output logic               out_valid,
  output snf_pkg::result_t   out_data,
  input  logic               out_stall
);
  snf_pkg::result_t skid;
  logic skid_valid;
  assign space = !skid_valid;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        if (skid_valid) begin
          out_data <= skid;
          out_valid <= 1'b1;
          skid_valid <= in_valid;
          skid <= in_data;
        end else begin
          out_valid <= in_valid;
          out_data <= in_data;
        end
      end else if (in_valid) begin
        skid_valid <= 1'b1;
        skid <= in_data;
      end
    end
  end
endmodule

// File: bench/spi_nor_flash_command_sequencer_checker.sv
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer_checker
// Watches the request, result and register channels of the sequencer. Every
// accepted item runs through a behavioral copy of the sequencer, which queues
// the result the item should produce. Every accepted result is compared field
// by field with the oldest queued one. The predicted sequencer phase and
// operation, a cycle count and an accepted item count are handed to the
// stimulus so that it can answer exchanges in step with the clock.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module spi_nor_flash_command_sequencer_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_stall,
  input  logic [3:0]      req_type,
  input  logic [23:0]     address,
  input  logic [23:0]     length,
  input  logic [7:0]      data_byte,
  input  logic            out_valid,
  input  logic            out_stall,
  input  logic            tx_valid,
  input  logic [7:0]      tx_byte,
  input  logic            frame_end,
  input  logic            host_valid,
  input  logic [7:0]      host_byte,
  input  logic [31:0]     crc_value,
  input  logic            done_res,
  input  logic [1:0]      status,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [0:0]      cfg_index,
  input  logic [23:0]     cfg_data,
  output int              mismatches,
  output int              pending,
  output int              cycles,
  output int              in_count,
  output snf_pkg::phase_t seq_phase,
  output logic [2:0]      seq_op
);
  localparam logic [31:0] FLASH_BYTES = 32'd8388608;
  localparam logic [23:0] FRAME_BYTES = 24'd256;

  logic [23:0] id_reg;
  logic [7:0]  mask_reg;
  logic [23:0] cur_addr;
  logic [23:0] bytes_left;
  logic [23:0] chunk;
  logic [23:0] page_idx;
  logic [23:0] frame_left;
  logic [31:0] crc_acc;
  logic [23:0] id_acc;
  logic [7:0]  page_mem [256];
  snf_pkg::result_t res;
  snf_pkg::result_t got;
  snf_pkg::result_t awaited_results[$];

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] want);
    $display("%0t: %s got %0h, expected %0h", $time, what, seen, want);
    mismatches++;
  endtask

  task automatic emit_tx(input logic [7:0] b, input logic fe, input snf_pkg::phase_t nxt);
    res.tx_valid = 1'b1;
    res.tx_byte = b;
    res.frame_end = fe;
    seq_phase = nxt;
  endtask

  task automatic emit_done(input logic [1:0] st);
    res.done_res = 1'b1;
    res.status = st;
    seq_phase = snf_pkg::PH_IDLE;
  endtask

  task automatic emit_data();
    logic [7:0] b;
    b = snf_pkg::DUMMY;
    if (seq_op == snf_pkg::OP_WRITE) begin
      b = page_mem[page_idx[7:0]];
      page_idx++;
    end
    frame_left--;
    emit_tx(b, frame_left == 24'd0, snf_pkg::PH_DATA);
  endtask

  task automatic open_crc_frame();
    chunk = bytes_left < FRAME_BYTES ? bytes_left : FRAME_BYTES;
    bytes_left -= chunk;
    frame_left = chunk;
    emit_tx(snf_pkg::CMD_READ, 1'b0, snf_pkg::PH_CMD);
  endtask

  task automatic open_page();
    logic [23:0] room;
    room = 24'd256 - {16'd0, cur_addr[7:0]};
    chunk = bytes_left < room ? bytes_left : room;
    bytes_left -= chunk;
    page_idx = '0;
    seq_phase = snf_pkg::PH_COLLECT;
  endtask

  task automatic close_frame();
    case (seq_op) inside
      snf_pkg::OP_READ, snf_pkg::OP_STATUS: emit_done(snf_pkg::ST_OK);
      snf_pkg::OP_ID: emit_done(id_acc == id_reg ? snf_pkg::ST_OK : snf_pkg::ST_ID);
      snf_pkg::OP_CRC: begin
        if (bytes_left > 24'd0) begin
          cur_addr += chunk;
          open_crc_frame();
        end else begin
          res.crc_value = ~crc_acc;
          emit_done(snf_pkg::ST_OK);
        end
      end
      default: emit_tx(snf_pkg::CMD_RDSR, 1'b0, snf_pkg::PH_POLLC);
    endcase
  endtask

  task automatic take_rx(input logic [7:0] rx);
    logic [7:0] cmd;
    case (seq_phase)
      snf_pkg::PH_WEN: begin
        page_idx = '0;
        frame_left = seq_op == snf_pkg::OP_WRITE ? chunk : 24'd0;
        cmd = seq_op == snf_pkg::OP_WRITE ? snf_pkg::CMD_PP :
              seq_op == snf_pkg::OP_SECTOR ? snf_pkg::CMD_SE :
              seq_op == snf_pkg::OP_BLOCK ? snf_pkg::CMD_BE : snf_pkg::CMD_CE;
        emit_tx(cmd, seq_op == snf_pkg::OP_CHIP, snf_pkg::PH_CMD);
      end
      snf_pkg::PH_CMD: begin
        if (seq_op == snf_pkg::OP_CHIP) close_frame();
        else if (seq_op == snf_pkg::OP_ID || seq_op == snf_pkg::OP_STATUS) emit_data();
        else emit_tx(cur_addr[23:16], 1'b0, snf_pkg::PH_A2);
      end
      snf_pkg::PH_A2: emit_tx(cur_addr[15:8], 1'b0, snf_pkg::PH_A1);
      snf_pkg::PH_A1: emit_tx(cur_addr[7:0], frame_left == 24'd0, snf_pkg::PH_A0);
      snf_pkg::PH_A0: begin
        if (frame_left > 24'd0) emit_data();
        else close_frame();
      end
      snf_pkg::PH_DATA: begin
        if (seq_op == snf_pkg::OP_READ || seq_op == snf_pkg::OP_ID ||
            seq_op == snf_pkg::OP_STATUS) begin
          res.host_valid = 1'b1;
          res.host_byte = rx;
        end
        if (seq_op == snf_pkg::OP_ID) id_acc = {id_acc[15:0], rx};
        if (seq_op == snf_pkg::OP_CRC) begin
          crc_acc ^= {24'd0, rx};
          for (int k = 0; k < 8; k++)
            crc_acc = (crc_acc >> 1) ^ (crc_acc[0] ? snf_pkg::CRC_POLY : 32'd0);
        end
        if (frame_left > 24'd0) emit_data();
        else close_frame();
      end
      snf_pkg::PH_POLLC: emit_tx(snf_pkg::DUMMY, 1'b1, snf_pkg::PH_POLLD);
      default: begin
        if ((rx & mask_reg) != 8'd0) begin
          emit_tx(snf_pkg::CMD_RDSR, 1'b0, snf_pkg::PH_POLLC);
        end else if (seq_op == snf_pkg::OP_WRITE) begin
          cur_addr += chunk;
          if (bytes_left == 24'd0) emit_done(snf_pkg::ST_OK);
          else open_page();
        end else begin
          emit_done(snf_pkg::ST_OK);
        end
      end
    endcase
  endtask

  task automatic take_request(input logic [3:0] t, input logic [23:0] a,
                              input logic [23:0] len);
    seq_op = t[2:0];
    cur_addr = a;
    case (t)
      snf_pkg::T_READ: begin
        frame_left = len;
        bytes_left = '0;
        emit_tx(snf_pkg::CMD_READ, 1'b0, snf_pkg::PH_CMD);
      end
      snf_pkg::T_WRITE: begin
        if ({8'd0, a} + {8'd0, len} > FLASH_BYTES) begin
          emit_done(snf_pkg::ST_RANGE);
        end else if (len == 24'd0) begin
          emit_done(snf_pkg::ST_OK);
        end else begin
          bytes_left = len;
          open_page();
        end
      end
      snf_pkg::T_ID: begin
        frame_left = 24'd3;
        id_acc = '0;
        emit_tx(snf_pkg::CMD_RDID, 1'b0, snf_pkg::PH_CMD);
      end
      snf_pkg::T_STATUS: begin
        frame_left = 24'd1;
        emit_tx(snf_pkg::CMD_RDSR, 1'b0, snf_pkg::PH_CMD);
      end
      snf_pkg::T_CRC: begin
        crc_acc = '1;
        if (len == 24'd0) begin
          emit_done(snf_pkg::ST_OK);
        end else begin
          bytes_left = len;
          open_crc_frame();
        end
      end
      default: begin
        frame_left = '0;
        emit_tx(snf_pkg::CMD_WREN, 1'b1, snf_pkg::PH_WEN);
      end
    endcase
  endtask

  task automatic predict_item(input logic [3:0] t, input logic [23:0] a,
                              input logic [23:0] len, input logic [7:0] d);
    logic bad;
    bad = 1'b0;
    res = '0;
    if (seq_phase == snf_pkg::PH_IDLE) begin
      if (t <= snf_pkg::T_CRC) take_request(t, a, len);
      else bad = 1'b1;
    end else if (seq_phase == snf_pkg::PH_COLLECT) begin
      if (t == snf_pkg::T_DATA) begin
        page_mem[page_idx[7:0]] = d;
        page_idx++;
        if (page_idx >= chunk) emit_tx(snf_pkg::CMD_WREN, 1'b1, snf_pkg::PH_WEN);
      end else begin
        bad = 1'b1;
      end
    end else begin
      if (t == snf_pkg::T_RX) take_rx(d);
      else bad = 1'b1;
    end
    if (bad) begin
      res = '0;
      res.status = snf_pkg::ST_BAD;
    end
    if (bad || res.tx_valid || res.host_valid || res.done_res)
      awaited_results.push_back(res);
  endtask

  task automatic compare_result(input snf_pkg::result_t want);
    if (got.tx_valid !== want.tx_valid)
      report_mismatch("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
    if (got.tx_byte !== want.tx_byte)
      report_mismatch("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
    if (got.frame_end !== want.frame_end)
      report_mismatch("frame_end", 32'(got.frame_end), 32'(want.frame_end));
    if (got.host_valid !== want.host_valid)
      report_mismatch("host_valid", 32'(got.host_valid), 32'(want.host_valid));
    if (got.host_byte !== want.host_byte)
      report_mismatch("host_byte", 32'(got.host_byte), 32'(want.host_byte));
    if (got.crc_value !== want.crc_value)
      report_mismatch("crc_value", got.crc_value, want.crc_value);
    if (got.done_res !== want.done_res)
      report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      id_reg = 24'hEF4017;
      mask_reg = 8'h01;
      seq_phase = snf_pkg::PH_IDLE;
      seq_op = snf_pkg::OP_READ;
      cur_addr = '0;
      bytes_left = '0;
      chunk = '0;
      page_idx = '0;
      frame_left = '0;
      crc_acc = '1;
      id_acc = '0;
      mismatches = 0;
      in_count = 0;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == snf_pkg::CFG_ID) id_reg = cfg_data;
        else mask_reg = cfg_data[7:0];
      end
      if (out_valid && !out_stall) begin
        got = '{tx_valid, tx_byte, frame_end, host_valid, host_byte, crc_value,
                done_res, status};
        if (awaited_results.size() == 0)
          report_mismatch("unexpected result, status", 32'(got.status), 32'd0);
        else
          compare_result(awaited_results.pop_front());
      end
      if (in_valid && !in_stall) begin
        predict_item(req_type, address, length, data_byte);
        in_count++;
      end
    end
    pending = awaited_results.size();
    cycles++;
  end
endmodule

// File: bench/tb_spi_nor_flash_command_sequencer_top.sv
// ----------------------------------------------------------------------------
// tb_spi_nor_flash_command_sequencer_top
// Drives host requests, page data and SPI answers into the sequencer and
// gives the verdict. Requests run as complete transactions: every exchange
// the sequencer starts is answered, with status polls and ID answers shaped
// so that busy loops end and ID checks both pass and fail. Stray items are
// mixed in, both channels idle at random, and the registers are changed
// between phases. Checking is done by the checker beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_spi_nor_flash_command_sequencer_top;
  localparam int ITEM_TARGET = 2000;
  localparam int IDLE_LIMIT = 5000;
  localparam logic [23:0] LAST_PAGE = 24'h7FFF00;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  req_type = '0;
  logic [23:0] address = '0;
  logic [23:0] length = '0;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        frame_end;
  logic        host_valid;
  logic [7:0]  host_byte;
  logic [31:0] crc_value;
  logic        done_res;
  logic [1:0]  status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  int          mismatches;
  int          pending;
  int          cycles;
  int          in_count;
  snf_pkg::phase_t seq_phase;
  logic [2:0]  seq_op;
  int          item_count = 0;
  int          idle_cycles = 0;
  int          junk_pct = 3;
  logic        calm = 1'b0;
  logic        id_good = 1'b0;
  int          id_pos = 0;
  logic [23:0] cur_id = 24'hEF4017;
  logic [7:0]  cur_mask = 8'h01;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  spi_nor_flash_command_sequencer_top i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .address(address), .length(length),
    .data_byte(data_byte), .out_valid(out_valid), .out_stall(out_stall),
    .tx_valid(tx_valid), .tx_byte(tx_byte), .frame_end(frame_end),
    .host_valid(host_valid), .host_byte(host_byte), .crc_value(crc_value),
    .done_res(done_res), .status(status), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  spi_nor_flash_command_sequencer_checker i_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .address(address), .length(length),
    .data_byte(data_byte), .out_valid(out_valid), .out_stall(out_stall),
    .tx_valid(tx_valid), .tx_byte(tx_byte), .frame_end(frame_end),
    .host_valid(host_valid), .host_byte(host_byte), .crc_value(crc_value),
    .done_res(done_res), .status(status), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .cycles(cycles),
    .in_count(in_count), .seq_phase(seq_phase), .seq_op(seq_op)
  );

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 12);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Waits for the next rising edge and for the checker to finish that edge.
  task automatic tick();
    int c;
    c = cycles;
    @(posedge clk);
    wait (cycles != c);
  endtask

  task automatic push_item(input logic [3:0] t, input logic [23:0] a,
                           input logic [23:0] len, input logic [7:0] d);
    int n;
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      tick();
    end
    in_valid <= 1'b1;
    req_type <= t;
    address <= a;
    length <= len;
    data_byte <= d;
    n = in_count;
    do tick(); while (in_count == n);
  endtask

  task automatic push_junk();
    int r;
    r = $urandom_range(14);
    if (seq_phase == snf_pkg::PH_IDLE) r = $urandom_range(8, 15);
    else if (seq_phase == snf_pkg::PH_COLLECT) r = r >= 8 ? r + 1 : r;
    else r = r >= 9 ? r + 1 : r;
    push_item(r[3:0], 24'($urandom), 24'($urandom), 8'($urandom));
  endtask

  function automatic logic [7:0] rx_answer();
    logic [7:0] b;
    b = 8'($urandom);
    if (seq_phase == snf_pkg::PH_POLLD) begin
      if (cur_mask != 8'd0 && $urandom_range(2) == 0)
        b = b | (cur_mask & (~cur_mask + 8'd1));
      else b = b & ~cur_mask;
    end else if (seq_phase == snf_pkg::PH_DATA && seq_op == snf_pkg::OP_ID) begin
      if (id_good) b = cur_id[23 - 8 * id_pos -: 8];
      id_pos++;
    end
    return b;
  endfunction

  task automatic run_request(input logic [3:0] t, input logic [23:0] a,
                             input logic [23:0] len);
    id_pos = 0;
    push_item(t, a, len, 8'($urandom));
    item_count++;
    while (seq_phase != snf_pkg::PH_IDLE) begin
      if ($urandom_range(99) < junk_pct) begin
        push_junk();
      end else begin
        if (seq_phase == snf_pkg::PH_COLLECT)
          push_item(snf_pkg::T_DATA, 24'($urandom), 24'($urandom), 8'($urandom));
        else push_item(snf_pkg::T_RX, 24'($urandom), 24'($urandom), rx_answer());
        item_count++;
      end
    end
  endtask

  task automatic random_request();
    logic [3:0]  t;
    logic [23:0] a;
    logic [23:0] len;
    t = 4'($urandom_range(7));
    len = ($urandom_range(9) == 0) ? 24'($urandom_range(257, 600)) :
                                     24'($urandom_range(0, 40));
    case ($urandom_range(3))
      0: a = 24'($urandom);
      1: a = 24'h800000 - 24'($urandom_range(0, 64));
      default: a = 24'($urandom_range(0, 24'h7FFC00));
    endcase
    id_good = 1'($urandom_range(1));
    if ($urandom_range(19) == 0) push_junk();
    run_request(t, a, len);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [23:0] val);
    in_valid <= 1'b0;
    while (pending != 0 || seq_phase != snf_pkg::PH_IDLE) tick();
    repeat (8) tick();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do tick(); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == snf_pkg::CFG_ID) cur_id = val;
    else cur_mask = val[7:0];
  endtask

  initial begin
    repeat (9) tick();
    rst <= 1'b0;

    push_item(snf_pkg::T_DATA, 24'hFFFFFF, 24'hFFFFFF, 8'hFF);
    push_item(snf_pkg::T_RX, 24'h0, 24'h0, 8'h00);
    push_item(4'hF, 24'h0, 24'h800000, 8'hA5);
    run_request(snf_pkg::T_STATUS, 24'h0, 24'h0);
    id_good = 1'b1;
    run_request(snf_pkg::T_ID, 24'h0, 24'h0);
    id_good = 1'b0;
    run_request(snf_pkg::T_ID, 24'h0, 24'h0);
    run_request(snf_pkg::T_READ, 24'hFFFFFE, 24'd0);
    run_request(snf_pkg::T_READ, 24'hFFFFFE, 24'd4);
    run_request(snf_pkg::T_WRITE, 24'h100, 24'd0);
    run_request(snf_pkg::T_WRITE, 24'h7FFFFF, 24'd2);
    run_request(snf_pkg::T_WRITE, 24'h0, 24'h800000 | 24'd1);
    run_request(snf_pkg::T_WRITE, LAST_PAGE + 24'hFE, 24'd2);
    run_request(snf_pkg::T_WRITE, 24'h0000FE, 24'd4);
    run_request(snf_pkg::T_SECTOR, 24'hFFFFFF, 24'd0);
    run_request(snf_pkg::T_BLOCK, 24'h123456, 24'd0);
    run_request(snf_pkg::T_CHIP, 24'h0, 24'd0);
    run_request(snf_pkg::T_CRC, 24'h0, 24'd0);
    run_request(snf_pkg::T_CRC, 24'hFFFFF0, 24'd300);
    junk_pct = 50;
    run_request(snf_pkg::T_WRITE, 24'h10, 24'd3);
    run_request(snf_pkg::T_READ, 24'h20, 24'd3);
    junk_pct = 3;

    write_reg(snf_pkg::CFG_ID, 24'h000000);
    write_reg(snf_pkg::CFG_MASK, 24'h0000FF);
    while (item_count < ITEM_TARGET / 3) random_request();
    write_reg(snf_pkg::CFG_ID, 24'hFFFFFF);
    write_reg(snf_pkg::CFG_MASK, 24'h000000);
    calm = 1'b1;
    while (item_count < ITEM_TARGET / 2) random_request();
    calm = 1'b0;
    while (item_count < 2 * ITEM_TARGET / 3) random_request();
    write_reg(snf_pkg::CFG_ID, 24'($urandom));
    write_reg(snf_pkg::CFG_MASK, 24'($urandom_range(1, 255)));
    while (item_count < ITEM_TARGET) random_request();

    in_valid <= 1'b0;
    while (pending != 0) tick();
    repeat (20) tick();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl
rtl/snf_pkg.sv
rtl/snf_page_ram.sv
rtl/snf_out_skid.sv
rtl/spi_nor_flash_command_sequencer_top.sv
bench/spi_nor_flash_command_sequencer_checker.sv
bench/tb_spi_nor_flash_command_sequencer_top.sv
